@@ sv/infix_to_postfix_converter_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the infix-to-postfix converter.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITP_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// Infix-to-postfix package
// Types, character codes and operator ranking shared by the converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [7:0]       char_t;
  typedef logic [1:0]       rank_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_CARET  = 8'h5E;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;

  localparam count_t COUNT_FULL = count_t'(STACK_DEPTH);
  localparam count_t COUNT_ONE  = count_t'(1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_t;

  // Shift controls for the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctl_t;

  function automatic rank_t rank_of(char_t c);
    rank_t r;
    case (c) inside
      CH_PLUS, CH_MINUS: r = 2'd1;
      CH_STAR, CH_SLASH: r = 2'd2;
      CH_CARET:          r = 2'd3;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

  // True when stacked operator t must be popped before operator c is pushed.
  function automatic logic pops_over(char_t t, char_t c);
    rank_t rt;
    rank_t rc;
    rt = rank_of(t);
    rc = rank_of(c);
    return (t != CH_LPAREN) && ((rt > rc) || ((rt == rc) && (c != CH_CARET)));
  endfunction

endpackage

@@ sv/itp_cell.sv @@
// ----------------------------------------------------------------------------
// Stack cell
// One operator stack entry that shifts down on push and up on pop.
// ----------------------------------------------------------------------------
module itp_cell
  import itp_pkg::*;
(
  input  logic     clk,
  input  stk_ctl_t ctl,
  input  char_t    up_data,
  input  char_t    down_data,
  output char_t    data
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= up_data;
    end else if (ctl.pop) begin
      data <= down_data;
    end
  end

endmodule

@@ sv/itp_stack.sv @@
// ----------------------------------------------------------------------------
// Operator stack
// A row of shifting cells with the top in cell zero, plus the fill count.
// ----------------------------------------------------------------------------
module itp_stack
  import itp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  stk_ctl_t ctl,
  input  char_t    push_data,
  output char_t    top,
  output char_t    second,
  output count_t   count
);

  char_t cell_q [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    char_t up_d;
    char_t down_d;
    if (i == 0) begin : g_first
      assign up_d = push_data;
    end else begin : g_mid
      assign up_d = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_d = cell_q[i];
    end else begin : g_inner
      assign down_d = cell_q[i+1];
    end
    itp_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .up_data   (up_d),
      .down_data (down_d),
      .data      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.clear) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + COUNT_ONE;
    end else if (ctl.pop) begin
      count <= count - COUNT_ONE;
    end
  end

  assign top    = cell_q[0];
  assign second = cell_q[1];

endmodule

@@ sv/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// Infix-to-postfix converter
// Shunting-yard conversion of an infix character stream to postfix order.
// ----------------------------------------------------------------------------
// Operation: a taken request is latched, then worked off in stack steps: one per
//   entry popped, plus one for the push, digit, terminator or error report.
//   Each result is registered in the output register, and a stalled output
//   holds back the next step. A new request is taken only once the last is done.
// Reset (rst, synchronous, active high) empties the stack and drops any result.
`include "infix_to_postfix_converter_macros.svh"

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [0:0] s_tuser,   // [0] cmd: 0 character, 1 end of expression
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic [1:0] m_tuser,   // [1:0] status
  output logic       m_tlast    // last result caused by the request
);

  // The converter is sequential: a request is latched, then worked off one
  // stack step per cycle while the output register has room.
  // The operator stack is a row of shifting cells, so one entry moves per cycle.
  state_t state;
  state_t state_next;

  logic   cmd_q;
  char_t  ch_q;

  // Stack interface.
  stk_ctl_t ctl;
  char_t    top;
  char_t    second;
  count_t   count;
  logic     empty;
  logic     full;
  logic     more;

  // One step of work.
  logic    slot_free;
  logic    emit;
  char_t   emit_char;
  status_t emit_status;
  logic    emit_last;
  logic    done;
  logic    is_digit;

  // Output register.
  char_t   out_char;
  status_t status;
  logic    last;

  itp_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .push_data (ch_q),
    .top       (top),
    .second    (second),
    .count     (count)
  );

  assign empty     = (count == '0);
  assign full      = (count == COUNT_FULL);
  assign more      = (count > COUNT_ONE);
  assign slot_free = !m_tvalid || m_tready;
  assign is_digit  = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);

  // Request capture.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_q <= s_tuser[0];
      ch_q  <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the controller: handshake and one stack step per cycle while the output register has room.
  // The last flag of a popped operator looks one cell ahead to see whether
  // the next step will emit anything.
  always_comb begin
    s_tready    = 1'b0;
    emit        = 1'b0;
    emit_char   = CH_NUL;
    emit_status = ST_OK;
    emit_last   = 1'b0;
    done        = 1'b0;
    ctl         = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_BUSY: begin
        if (slot_free) begin
          if (cmd_q) begin
            // Flush: pop everything, then the terminator.
            emit = 1'b1;
            if (!empty) begin
              emit_char = top;
              ctl.pop   = 1'b1;
            end else begin
              emit_last = 1'b1;
              done      = 1'b1;
            end
          end else if (is_digit) begin
            emit      = 1'b1;
            emit_char = ch_q;
            emit_last = 1'b1;
            done      = 1'b1;
          end else if (ch_q == CH_LPAREN) begin
            if (full) begin
              emit        = 1'b1;
              emit_status = ST_OVERFLOW;
              emit_last   = 1'b1;
              ctl.clear   = 1'b1;
            end else begin
              ctl.push = 1'b1;
            end
            done = 1'b1;
          end else if (ch_q == CH_RPAREN) begin
            if (empty) begin
              // Ran out of entries without a matching open parenthesis.
              emit        = 1'b1;
              emit_status = ST_UNMATCHED;
              emit_last   = 1'b1;
              done        = 1'b1;
            end else if (top == CH_LPAREN) begin
              ctl.pop = 1'b1;
              done    = 1'b1;
            end else begin
              emit      = 1'b1;
              emit_char = top;
              emit_last = more && (second == CH_LPAREN);
              ctl.pop   = 1'b1;
            end
          end else begin
            // Any other character is an operator.
            if (!empty && pops_over(top, ch_q)) begin
              emit      = 1'b1;
              emit_char = top;
              emit_last = !(more && pops_over(second, ch_q));
              ctl.pop   = 1'b1;
            end else if (full) begin
              emit        = 1'b1;
              emit_status = ST_OVERFLOW;
              emit_last   = 1'b1;
              ctl.clear   = 1'b1;
              done        = 1'b1;
            end else begin
              ctl.push = 1'b1;
              done     = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Output register; it is only loaded when it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= emit_char;
      status   <= emit_status;
      last     <= emit_last;
    end
  end

  assign m_tdata = out_char;
  assign m_tuser = status;
  assign m_tlast = last;

  `ITP_ASSERT_SAME(a_count_bound, 1'b1, count <= COUNT_FULL, "stack count beyond depth")
  `ITP_ASSERT_SAME(a_push_room, ctl.push, !full && !ctl.pop, "push into a full stack")
  `ITP_ASSERT_SAME(a_pop_entry, ctl.pop, !empty, "pop from an empty stack")
  `ITP_ASSERT_SAME(a_error_last, m_tvalid && (status != ST_OK), last && (out_char == CH_NUL),
                   "error result not final or not blank")
  `ITP_ASSERT_NEXT(a_emit_room, emit && m_tvalid, m_tvalid, "result written into a busy slot")

endmodule
